// ===== design/assert_macros.svh =====
// Assertion macros shared by the vector clock table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising edge of clk outside reset.
`define VCT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vector clock table check failed");
// Next-cycle implication, checked on every rising edge of clk outside reset.
`define VCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vector clock table check failed");
`else
`define VCT_ASSERT_IMPL(label, ante, cons)
`define VCT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/vct_pkg.sv =====
// Types and constants shared by the vector clock table modules.
package vct_pkg;

  localparam int FIELD_W = 2;
  localparam int OUT_VALUE_W = 16;

  // Event kinds carried on in_operation.
  localparam logic [FIELD_W-1:0] OP_LOCAL = 2'd0;
  localparam logic [FIELD_W-1:0] OP_SEND  = 2'd1;
  localparam logic [FIELD_W-1:0] OP_RECV  = 2'd2;

  // One classified event request waiting for the back end.
  typedef struct packed {
    logic               is_recv;
    logic [FIELD_W-1:0] act;
    logic [FIELD_W-1:0] src;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } back_state_t;

endpackage

// ===== design/vct_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module vct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rda_addr,
  output logic [WIDTH-1:0]         rda_data,
  input  logic [$clog2(DEPTH)-1:0] rdb_addr,
  output logic [WIDTH-1:0]         rdb_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rda_r;
  logic [WIDTH-1:0] rdb_r;

  // Write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rda_r <= mem_r[rda_addr];
    rdb_r <= mem_r[rdb_addr];
  end

  assign rda_data = rda_r;
  assign rdb_data = rdb_r;

endmodule

// ===== design/vct_front.sv =====
// Front end: accepts event requests, drops invalid ones and queues the rest.
`include "assert_macros.svh"
module vct_front #(
  parameter int NODES = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [vct_pkg::FIELD_W-1:0]    in_operation,
  input  logic [vct_pkg::FIELD_W-1:0]    in_acting_node,
  input  logic [vct_pkg::FIELD_W-1:0]    in_source_node,
  output logic                           q_valid,
  output vct_pkg::cmd_t                  q_cmd,
  input  logic                           q_pop
);

  vct_pkg::cmd_t ent_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  logic          act_ok;
  logic          src_ok;
  logic          keep;
  logic          push;

  // Node numbers beyond the table make the request a no-op.
  assign act_ok = (32'(in_acting_node) < NODES);
  assign src_ok = (32'(in_source_node) < NODES);

  // Classify the event kind; the unused code is dropped.
  always_comb begin
    unique case (in_operation) inside
      vct_pkg::OP_LOCAL, vct_pkg::OP_SEND: keep = act_ok;
      vct_pkg::OP_RECV:                    keep = act_ok && src_ok;
      default:                             keep = 1'b0;
    endcase
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy && keep;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Two-entry queue control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Queue payload.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= '{is_recv: (in_operation == vct_pkg::OP_RECV),
                           act:     in_acting_node,
                           src:     in_source_node};
    end
  end

  `VCT_ASSERT_IMPL(a_pop_needs_entry, q_pop, cnt_r != 2'd0)

endmodule

// ===== design/vct_back.sv =====
// Back end: walks the acting row element by element, merges, bumps and emits.
`include "assert_macros.svh"
module vct_back #(
  parameter int NODES       = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  vct_pkg::cmd_t                     q_cmd,
  output logic                              q_pop,
  output logic                              out_strobe,
  output logic [vct_pkg::FIELD_W-1:0]       out_element_index,
  output logic [vct_pkg::OUT_VALUE_W-1:0]   out_element_value,
  output logic                              out_saturated,
  output logic                              out_last
);

  localparam int DEPTH = NODES * NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(NODES);
  localparam logic [KW-1:0]          K_LAST = KW'(NODES - 1);
  localparam logic [COUNT_WIDTH-1:0] C_MAX  = '1;

  vct_pkg::back_state_t state_r;
  vct_pkg::back_state_t state_nxt;
  vct_pkg::cmd_t        cmd_r;
  logic [KW-1:0]        rd_k_r;
  logic                 rd_en;
  logic [AW-1:0]        act_addr;
  logic [AW-1:0]        src_addr;
  logic [DEPTH-1:0]     vld_r;

  logic                 s1_vld_r;
  logic                 s1_last_r;
  logic [KW-1:0]        s1_k_r;
  logic [AW-1:0]        s1_addr_r;
  logic                 a_hit_r;
  logic                 s_hit_r;

  logic [COUNT_WIDTH-1:0] a_q;
  logic [COUNT_WIDTH-1:0] s_q;
  logic [COUNT_WIDTH-1:0] a_val;
  logic [COUNT_WIDTH-1:0] s_val;
  logic [COUNT_WIDTH-1:0] merged;
  logic [COUNT_WIDTH-1:0] new_val;
  logic                   own;

  logic                           out_strobe_r;
  logic [vct_pkg::FIELD_W-1:0]    out_index_r;
  logic [vct_pkg::OUT_VALUE_W-1:0] out_value_r;
  logic                           out_sat_r;
  logic                           out_last_r;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vct_pkg::ST_IDLE:  if (q_valid) state_nxt = vct_pkg::ST_RUN;
      vct_pkg::ST_RUN:   if (rd_k_r == K_LAST) state_nxt = vct_pkg::ST_DRAIN;
      vct_pkg::ST_DRAIN: state_nxt = q_valid ? vct_pkg::ST_RUN : vct_pkg::ST_IDLE;
      default:           state_nxt = vct_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs. The drain cycle lets the last write land before the
  // next request reads the table.
  always_comb begin
    q_pop = 1'b0;
    rd_en = 1'b0;
    unique case (state_r)
      vct_pkg::ST_IDLE:  q_pop = q_valid;
      vct_pkg::ST_RUN:   rd_en = 1'b1;
      vct_pkg::ST_DRAIN: q_pop = q_valid;
      default:           q_pop = 1'b0;
    endcase
  end

  // Table addresses of element k in the acting and source rows.
  assign act_addr = AW'(32'(cmd_r.act) * NODES + 32'(rd_k_r));
  assign src_addr = AW'(32'(cmd_r.src) * NODES + 32'(rd_k_r));

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= vct_pkg::ST_IDLE;
      rd_k_r       <= '0;
      s1_vld_r     <= 1'b0;
      s1_last_r    <= 1'b0;
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        rd_k_r <= '0;
      end else if (rd_en) begin
        rd_k_r <= rd_k_r + KW'(1);
      end
      s1_vld_r  <= rd_en;
      s1_last_r <= rd_en && (rd_k_r == K_LAST);
      if (s1_vld_r) begin
        vld_r[s1_addr_r] <= 1'b1;
      end
      out_strobe_r <= s1_vld_r;
    end
  end

  // Request and read-stage payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    s1_k_r    <= rd_k_r;
    s1_addr_r <= act_addr;
    a_hit_r   <= vld_r[act_addr];
    s_hit_r   <= vld_r[src_addr];
  end

  vct_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_table (
    .clk      (clk),
    .wr_en    (s1_vld_r),
    .wr_addr  (s1_addr_r),
    .wr_data  (new_val),
    .rda_addr (act_addr),
    .rda_data (a_q),
    .rdb_addr (src_addr),
    .rdb_data (s_q)
  );

  // Entries never written read as zero. Merge by maximum, then bump own entry.
  assign a_val   = a_hit_r ? a_q : '0;
  assign s_val   = s_hit_r ? s_q : '0;
  assign merged  = (cmd_r.is_recv && (s_val > a_val)) ? s_val : a_val;
  assign own     = (32'(s1_k_r) == 32'(cmd_r.act));
  assign new_val = (own && (merged != C_MAX)) ? merged + COUNT_WIDTH'(1) : merged;

  // Result register.
  always_ff @(posedge clk) begin
    out_index_r <= vct_pkg::FIELD_W'(s1_k_r);
    out_value_r <= vct_pkg::OUT_VALUE_W'(new_val);
    out_sat_r   <= (new_val == C_MAX);
    out_last_r  <= s1_last_r;
  end

  assign out_strobe        = out_strobe_r;
  assign out_element_index = out_index_r;
  assign out_element_value = out_value_r;
  assign out_saturated     = out_sat_r;
  assign out_last          = out_last_r;

  `VCT_ASSERT_NEXT(a_gap_after_last, out_strobe_r && out_last_r, !out_strobe_r)
  `VCT_ASSERT_NEXT(a_index_steps, out_strobe_r && !out_last_r,
                   out_strobe_r && (out_index_r == 2'($past(out_index_r) + 2'd1)))
  `VCT_ASSERT_IMPL(a_pop_not_running, q_pop, !rd_en && !(s1_vld_r && !s1_last_r))

endmodule

// ===== design/vector_clock_table.sv =====
// Top level of the vector clock table: front end, request queue and back end.
//
// Usage: drive in_operation, in_acting_node and in_source_node with start high;
// the request is taken at a rising edge where start is high and busy is low.
// Operation 0 (local) and 1 (send) bump the acting node's own entry; operation
// 2 (receive) first merges the source node's vector by element-wise maximum.
// Requests with the unused operation code or an out-of-range node are dropped
// and produce no results.
// Each kept request produces NODES results on out_strobe, element 0 first, with
// out_last on the final one. The receiver cannot hold results off; each result
// is present for exactly one cycle.
// The request passes through the queue, the request register, the registered
// table read and the result register before its first result strobes.
// The back end reads and writes one table element per cycle through the table
// RAM, then waits in a drain state for the final write to land before it takes
// the next request. A two-entry queue holds waiting requests; busy is high
// while it is full.
// Reset (synchronous, rst_n low) empties the queue and marks every table entry
// as zero through per-entry valid bits; no clearing pass is needed.
module vector_clock_table #(
  parameter int NODES       = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [vct_pkg::FIELD_W-1:0]     in_operation,
  input  logic [vct_pkg::FIELD_W-1:0]     in_acting_node,
  input  logic [vct_pkg::FIELD_W-1:0]     in_source_node,
  output logic                            out_strobe,
  output logic [vct_pkg::FIELD_W-1:0]     out_element_index,
  output logic [vct_pkg::OUT_VALUE_W-1:0] out_element_value,
  output logic                            out_saturated,
  output logic                            out_last
);

  logic          q_valid;
  logic          q_pop;
  vct_pkg::cmd_t q_cmd;

  vct_front #(
    .NODES (NODES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_acting_node (in_acting_node),
    .in_source_node (in_source_node),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop)
  );

  vct_back #(
    .NODES       (NODES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .out_strobe        (out_strobe),
    .out_element_index (out_element_index),
    .out_element_value (out_element_value),
    .out_saturated     (out_saturated),
    .out_last          (out_last)
  );

endmodule
